@@ sv/hft_pkg.sv @@
// hft_pkg: shared constants, operation codes, state type and write-port
// structs for the handle table with free list. No dependencies.
package hft_pkg;

  localparam int HANDLE_W = 10;
  localparam int VALUE_W  = 32;
  // One memory entry per handle value.
  localparam int CAPACITY = 2 ** HANDLE_W;

  localparam logic [HANDLE_W:0]   CAP_EXT = (HANDLE_W + 1)'(CAPACITY);
  localparam logic [HANDLE_W-1:0] CNT_MAX = HANDLE_W'(CAPACITY - 1);

  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_GET    = 2'd2;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic                we;
    logic [HANDLE_W-1:0] addr;
    logic [VALUE_W-1:0]  data;
  } val_wr_t;

  typedef struct packed {
    logic                we;
    logic [HANDLE_W-1:0] addr;
    logic [HANDLE_W-1:0] data;
  } link_wr_t;

endpackage

@@ sv/hft_ram.sv @@
// hft_ram: simple dual-port synchronous RAM, one write and one read port,
// read data registered. No dependencies.
module hft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/hft_ctrl.sv @@
// hft_ctrl: sequencer for the handle table: clearing pass, read/modify/write
// of the value and link memories, free-list head and add count.
// Depends on hft_pkg.
module hft_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [hft_pkg::HANDLE_W-1:0]  handle,
  input  logic [hft_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output logic [hft_pkg::HANDLE_W-1:0]  out_handle,
  output logic [hft_pkg::VALUE_W-1:0]   out_value,
  output logic                          rejected,
  output hft_pkg::val_wr_t              val_wr,
  output logic [hft_pkg::HANDLE_W-1:0]  val_raddr,
  input  logic [hft_pkg::VALUE_W-1:0]   val_rdata,
  output hft_pkg::link_wr_t             link_wr,
  output logic [hft_pkg::HANDLE_W-1:0]  link_raddr,
  input  logic [hft_pkg::HANDLE_W-1:0]  link_rdata
);

  hft_pkg::state_t state, state_next;

  logic [1:0]                   op_q;
  logic [hft_pkg::HANDLE_W-1:0] h_q;
  logic [hft_pkg::VALUE_W-1:0]  v_q;
  logic [hft_pkg::HANDLE_W-1:0] free_head, free_head_next;
  logic [hft_pkg::HANDLE_W-1:0] add_count, add_count_next;
  logic [hft_pkg::HANDLE_W-1:0] clr_idx;

  logic                         res_load;
  logic [hft_pkg::HANDLE_W-1:0] out_handle_next;
  logic [hft_pkg::VALUE_W-1:0]  out_value_next;
  logic                         rejected_next;

  logic [hft_pkg::HANDLE_W:0]   fresh;
  logic                         handle_ok;

  assign busy       = (state != hft_pkg::ST_IDLE);
  // Reads run every cycle; in EXEC the data belongs to the accept edge.
  assign val_raddr  = handle;
  assign link_raddr = free_head;

  assign fresh     = {1'b0, add_count} + (hft_pkg::HANDLE_W + 1)'(1);
  assign handle_ok = (h_q != '0) && (h_q <= add_count);

  always_comb begin
    state_next      = state;
    free_head_next  = free_head;
    add_count_next  = add_count;
    res_load        = 1'b0;
    out_handle_next = '0;
    out_value_next  = '0;
    rejected_next   = 1'b1;
    val_wr          = '0;
    link_wr         = '0;

    unique case (state)
      hft_pkg::ST_CLEAR: begin
        val_wr.we   = 1'b1;
        val_wr.addr = clr_idx;
        if (clr_idx == hft_pkg::CNT_MAX) begin
          state_next = hft_pkg::ST_IDLE;
        end
      end
      hft_pkg::ST_IDLE: begin
        if (start) begin
          state_next = hft_pkg::ST_EXEC;
        end
      end
      hft_pkg::ST_EXEC: begin
        state_next = hft_pkg::ST_IDLE;
        res_load   = 1'b1;
        unique case (op_q)
          hft_pkg::FUNC_ADD: begin
            if (free_head != '0) begin
              // reuse head of free list; link read was issued at accept
              rejected_next   = 1'b0;
              out_handle_next = free_head;
              free_head_next  = link_rdata;
            end else if (fresh < hft_pkg::CAP_EXT) begin
              rejected_next   = 1'b0;
              out_handle_next = fresh[hft_pkg::HANDLE_W-1:0];
              free_head_next  = '0;
            end
            if (!rejected_next) begin
              val_wr.we   = 1'b1;
              val_wr.addr = out_handle_next;
              val_wr.data = v_q;
              if (add_count != hft_pkg::CNT_MAX) begin
                add_count_next = add_count + hft_pkg::HANDLE_W'(1);
              end
            end
          end
          hft_pkg::FUNC_DELETE: begin
            if (handle_ok) begin
              rejected_next  = 1'b0;
              out_value_next = val_rdata;
              val_wr.we      = 1'b1;
              val_wr.addr    = h_q;
              link_wr.we     = 1'b1;
              link_wr.addr   = h_q;
              link_wr.data   = free_head;
              free_head_next = h_q;
            end
          end
          hft_pkg::FUNC_GET: begin
            if (handle_ok) begin
              rejected_next  = 1'b0;
              out_value_next = val_rdata;
            end
          end
          default: begin
            rejected_next = 1'b1;
          end
        endcase
      end
      default: begin
        state_next = hft_pkg::ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hft_pkg::ST_CLEAR;
      clr_idx   <= '0;
      free_head <= '0;
      add_count <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      add_count <= add_count_next;
      done      <= res_load;
      if (state == hft_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + hft_pkg::HANDLE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == hft_pkg::ST_IDLE && start) begin
      op_q <= func;
      h_q  <= handle;
      v_q  <= value;
    end
    if (res_load) begin
      out_handle <= out_handle_next;
      out_value  <= out_value_next;
      rejected   <= rejected_next;
    end
  end

`ifndef ASSERT_OFF
  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == hft_pkg::ST_EXEC)
    else $error("result strobe without an executed beat");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && rejected |-> out_handle == '0 && out_value == '0)
    else $error("rejected result carries payload");

  a_add_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && !rejected && op_q == hft_pkg::FUNC_ADD |-> out_handle != '0)
    else $error("add handed out reserved slot");

  // the load of the head by reset itself is not a move
  a_head_moves_in_exec: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(free_head) |-> $past(state) == hft_pkg::ST_EXEC)
    else $error("free-list head changed outside execution");
`endif

endmodule

@@ sv/handle_table_free_list.sv @@
// Handle table with free list: a beat accepted in IDLE runs through EXEC, and the result
// registers and the done strobe load at the end of EXEC; a new beat is taken only after
// the read-then-write round trip through the value and link memories is through.
// Reset (synchronous, rst high) starts a clearing pass over all 1024 value-memory entries
// with busy held high; results come as a one-cycle done strobe, the receiver cannot stall.
// Depends on hft_pkg, hft_ram and hft_ctrl.
module handle_table_free_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [hft_pkg::HANDLE_W-1:0]  handle,
  input  logic [hft_pkg::VALUE_W-1:0]   value,
  output logic                          done,
  output logic [hft_pkg::HANDLE_W-1:0]  out_handle,
  output logic [hft_pkg::VALUE_W-1:0]   out_value,
  output logic                          rejected
);

  // Write requests from the sequencer to each memory.
  hft_pkg::val_wr_t             val_wr;
  hft_pkg::link_wr_t            link_wr;
  logic [hft_pkg::HANDLE_W-1:0] val_raddr;
  logic [hft_pkg::VALUE_W-1:0]  val_rdata;
  logic [hft_pkg::HANDLE_W-1:0] link_raddr;
  logic [hft_pkg::HANDLE_W-1:0] link_rdata;

  // Sequencer: a beat is taken in IDLE, reads land during EXEC, writes,
  // free-list update and the result register are all committed at the end of EXEC.
  hft_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .handle     (handle),
    .value      (value),
    .done       (done),
    .out_handle (out_handle),
    .out_value  (out_value),
    .rejected   (rejected),
    .val_wr     (val_wr),
    .val_raddr  (val_raddr),
    .val_rdata  (val_rdata),
    .link_wr    (link_wr),
    .link_raddr (link_raddr),
    .link_rdata (link_rdata)
  );

  // Stored values; cleared by the pass after reset, zeroed again on delete.
  hft_ram #(
    .WIDTH (hft_pkg::VALUE_W),
    .DEPTH (hft_pkg::CAPACITY)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_wr.we),
    .waddr (val_wr.addr),
    .wdata (val_wr.data),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  // Free-list links: an entry is only ever read after a delete has written
  // it, and a fresh slot ends the list directly, so no clearing is needed.
  hft_ram #(
    .WIDTH (hft_pkg::HANDLE_W),
    .DEPTH (hft_pkg::CAPACITY)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_wr.we),
    .waddr (link_wr.addr),
    .wdata (link_wr.data),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

endmodule
